// File: rtl/clld_pkg.sv
// ----------------------------------------------------------------------------
// clld_pkg: shared types and constants of the content-length deframer
// Header text, separator text, window geometry and cell hand-off structs.
// ----------------------------------------------------------------------------
package clld_pkg;

  // Window geometry
  localparam int unsigned WinLen = 16;
  localparam int unsigned SepLen = 3;
  localparam int unsigned OutLenBits = 24;

  // Header literal "Content-Length: ", oldest byte first
  localparam logic [7:0] HdrText [WinLen] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
  };

  // Separator LF CR LF at the newest end of the window
  localparam logic [7:0] SepText [SepLen] = '{8'h0A, 8'h0D, 8'h0A};

  localparam logic [7:0] CharCr  = 8'h0D;
  localparam logic [7:0] CharNul = 8'h00;

  // Control broadcast to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  // Compare results of one window cell
  typedef struct packed {
    logic hdr;
    logic sep;
  } cell_hit_t;

endpackage

// File: rtl/clld_if.sv
// ----------------------------------------------------------------------------
// clld_if: stream channels of the content-length deframer
// Input byte channel and output result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface clld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface clld_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  body_byte;
  logic        is_last;
  logic        frame_empty;
  logic [23:0] frame_length;

  modport source (output valid, output body_byte, output is_last,
                  output frame_empty, output frame_length, input ready);
  modport sink   (input valid, input body_byte, input is_last,
                  input frame_empty, input frame_length, output ready);
endinterface

// File: rtl/clld_win_cell.sv
// ----------------------------------------------------------------------------
// clld_win_cell: one byte cell of the header match window
// Holds one window byte, takes its neighbour's byte on a shift and compares
// the incoming byte, the value it holds after a shift, against its header
// and separator characters.
// ----------------------------------------------------------------------------
module clld_win_cell #(
  parameter logic [7:0] HDR_CHAR = 8'h00,
  parameter logic [7:0] SEP_CHAR = 8'h00,
  parameter bit         SEP_USE  = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clld_pkg::win_ctrl_t   ctrl_i,
  input  logic [7:0]            byte_i,
  output logic [7:0]            byte_o,
  output clld_pkg::cell_hit_t   hit_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;
  logic [7:0] next_val;

  // Value after a shift, before any clear
  assign next_val = ctrl_i.shift ? byte_i : byte_q;

  // Compare the value held after a shift; only looked at on a shift
  assign hit_o.hdr = (byte_i == HDR_CHAR);
  assign hit_o.sep = SEP_USE ? (byte_i == SEP_CHAR) : 1'b1;

  // Clear wins over shift
  always_comb begin
    byte_d = next_val;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// File: rtl/content_length_deframer_unit.sv
// ----------------------------------------------------------------------------
// content_length_deframer_unit: content-length framed stream deframer
// Finds "Content-Length: ", reads the decimal length, waits for LF CR LF
// and passes on that many non-NUL body bytes, marking the last; zero gives an empty beat.
// ----------------------------------------------------------------------------
// One input byte is accepted every clock cycle while the output register is
// empty or being taken in the same cycle, so the block sustains one byte per
// cycle with a ready downstream. Each byte is handled in the cycle it is
// accepted: the header and separator are matched by a row of 16 byte cells
// that shift the window and compare in parallel, the length field is built
// with one multiply-by-ten-and-add per digit, and the body is counted down by
// one counter. A result is registered and appears on the output in the cycle
// after its byte is accepted. There is no start-up sweep after reset.
module content_length_deframer_unit #(
  parameter int unsigned FIELD_LIMIT = 256,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  clld_in_if.sink           in_i,
  clld_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(FIELD_LIMIT + 1);
  localparam int unsigned WinLen = clld_pkg::WinLen;
  localparam int unsigned SepLen = clld_pkg::SepLen;

  typedef enum logic [1:0] {
    PhHunt   = 2'd0,
    PhDigits = 2'd1,
    PhSep    = 2'd2,
    PhBody   = 2'd3
  } phase_e;

  // Control state
  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] length_q, length_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   done_q, done_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;

  // Output register
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_byte_q, out_byte_d;
  logic                   out_last_q, out_last_d;
  logic                   out_empty_q, out_empty_d;
  logic [23:0]            out_len_q, out_len_d;

  logic                   accept;
  logic                   non_nul;
  logic                   is_digit;
  logic                   hdr_match;
  logic                   sep_match;
  logic [LENGTH_BITS+3:0] mac;
  logic [CntW-1:0]        count_inc;
  logic [LENGTH_BITS-1:0] remain_dec;

  clld_pkg::win_ctrl_t    win_ctrl;
  logic [7:0]             win_byte [WinLen];
  logic [7:0]             win_feed [WinLen];
  clld_pkg::cell_hit_t    win_hit  [WinLen];
  logic [WinLen-1:0]      hdr_hits;
  logic [WinLen-1:0]      sep_hits;

  // Handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign non_nul    = (in_i.in_byte != clld_pkg::CharNul);
  assign is_digit   = (in_i.in_byte inside {[8'h30:8'h39]});

  // Window control: shift non-NUL bytes while hunting or awaiting the separator, clear on separator
  assign win_ctrl.shift = accept && non_nul && (phase_q == PhHunt || phase_q == PhSep);
  assign win_ctrl.clear = win_ctrl.shift && (phase_q == PhSep) && sep_match;

  // Row of window cells, newest byte enters at the last cell
  for (genvar i = 0; i < WinLen; i++) begin : g_cell
    if (i == WinLen - 1) begin : g_feed_in
      assign win_feed[i] = in_i.in_byte;
    end else begin : g_feed_nb
      assign win_feed[i] = win_byte[i+1];
    end

    clld_win_cell #(
      .HDR_CHAR (clld_pkg::HdrText[i]),
      .SEP_CHAR ((i >= WinLen - SepLen) ? clld_pkg::SepText[(i + SepLen - WinLen) % SepLen]
                                        : 8'h00),
      .SEP_USE  (i >= WinLen - SepLen)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (win_ctrl),
      .byte_i (win_feed[i]),
      .byte_o (win_byte[i]),
      .hit_o  (win_hit[i])
    );

    assign hdr_hits[i] = win_hit[i].hdr;
    assign sep_hits[i] = win_hit[i].sep;
  end

  assign hdr_match = &hdr_hits;
  assign sep_match = &sep_hits;

  // Length accumulate: value * 10 + digit
  assign mac = (LENGTH_BITS+4)'({length_q, 3'b000})
             + (LENGTH_BITS+4)'({length_q, 1'b0})
             + (LENGTH_BITS+4)'(in_i.in_byte[3:0]);

  assign count_inc  = count_q + 1'b1;
  assign remain_dec = remain_q - 1'b1;

  // Next state
  always_comb begin
    phase_d     = phase_q;
    length_d    = length_q;
    count_d     = count_q;
    done_d      = done_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_len_d   = out_len_q;

    if (accept) begin
      case (phase_q)
        PhHunt: begin
          if (non_nul && hdr_match) begin
            phase_d  = PhDigits;
            length_d = '0;
            count_d  = '0;
            done_d   = 1'b0;
          end
        end
        PhDigits: begin
          if (in_i.in_byte == clld_pkg::CharCr) begin
            phase_d = PhSep;
          end else begin
            if (!done_q && is_digit) begin
              length_d = (mac[LENGTH_BITS+3:LENGTH_BITS] != '0) ? '1
                                                                : mac[LENGTH_BITS-1:0];
            end else begin
              done_d = 1'b1;
            end
            count_d = count_inc;
            if (count_inc >= CntW'(FIELD_LIMIT)) begin
              phase_d = PhSep;
            end
          end
        end
        PhSep: begin
          if (non_nul && sep_match) begin
            if (length_q == '0) begin
              phase_d     = PhHunt;
              remain_d    = '0;
              out_valid_d = 1'b1;
              out_byte_d  = '0;
              out_last_d  = 1'b1;
              out_empty_d = 1'b1;
              out_len_d   = 24'(length_q);
            end else begin
              remain_d = length_q;
              phase_d  = PhBody;
            end
          end
        end
        PhBody: begin
          if (non_nul) begin
            remain_d    = remain_dec;
            out_valid_d = 1'b1;
            out_byte_d  = in_i.in_byte;
            out_empty_d = 1'b0;
            out_len_d   = 24'(length_q);
            out_last_d  = (remain_dec == '0);
            if (remain_dec == '0) begin
              phase_d = PhHunt;
            end
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      length_q    <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      length_q    <= length_d;
      count_q     <= count_d;
      done_q      <= done_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_len_q   <= out_len_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.body_byte    = out_byte_q;
  assign out_o.is_last      = out_last_q;
  assign out_o.frame_empty  = out_empty_q;
  assign out_o.frame_length = out_len_q;

  // Checks
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_last_q && (out_byte_q == 8'h00))
    else $error("empty frame beat not marked last with zero byte");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhBody |-> remain_q != '0)
    else $error("body phase with nothing left to pass");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FIELD_LIMIT))
    else $error("length field byte count beyond limit");

  a_beat_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !(phase_q == PhSep || phase_q == PhBody) |=> !out_valid_q || $stable(out_byte_q))
    else $error("result beat produced outside separator or body phase");

endmodule
